[rtl/qrs_pkg.sv]
// ---------------------------------------------------------------------------
// qrs_pkg: shared definitions for the quadratic root solver
// Default widths and the result kind codes.
// ---------------------------------------------------------------------------
package qrs_pkg;

  localparam int COEF_WIDTH_DEF     = 16;
  localparam int ROOT_FRAC_BITS_DEF = 16;
  localparam int ROOT_W             = 32;
  localparam int KIND_W             = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_LINEAR = 3'd0,
    KIND_NONE   = 3'd1,
    KIND_DOUBLE = 3'd2,
    KIND_TWO    = 3'd3,
    KIND_DEGEN  = 3'd4
  } kind_t;

endpackage

[rtl/qrs_front.sv]
// ---------------------------------------------------------------------------
// qrs_front: coefficient products and discriminant
// Stage 0 forms b*b and a*c on magnitudes, stage 1 forms the discriminant
// and the preliminary result kind.
// ---------------------------------------------------------------------------
module qrs_front
  import qrs_pkg::*;
#(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [COEF_WIDTH-1:0] in_quad,
  input  logic signed [COEF_WIDTH-1:0] in_lin,
  input  logic signed [COEF_WIDTH-1:0] in_const,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2*COEF_WIDTH:0]   out_delta,
  output kind_t                   out_kind,
  output logic signed [COEF_WIDTH-1:0] out_quad,
  output logic signed [COEF_WIDTH-1:0] out_lin,
  output logic signed [COEF_WIDTH-1:0] out_const
);

  localparam int W  = COEF_WIDTH;
  localparam int PW = 2 * W;
  localparam int DW = 2 * W + 1;

  logic [1:0] v_r;
  logic [2:0] rdy;

  assign rdy[2]   = out_ready;
  assign rdy[1]   = !v_r[1] || rdy[2];
  assign rdy[0]   = !v_r[0] || rdy[1];
  assign in_ready = rdy[0];
  assign out_valid = v_r[1];

  logic [W-1:0]  ma, mb, mc;
  logic [PW-1:0] bb_nxt, ac_nxt;

  assign ma = in_quad[W-1]  ? W'(-in_quad)  : W'(in_quad);
  assign mb = in_lin[W-1]   ? W'(-in_lin)   : W'(in_lin);
  assign mc = in_const[W-1] ? W'(-in_const) : W'(in_const);
  assign bb_nxt = PW'(mb) * PW'(mb);
  assign ac_nxt = PW'(ma) * PW'(mc);

  logic [PW-1:0] bb_r, ac_r;
  logic          acneg_r, azero_r, bzero_r;
  logic signed [W-1:0] a0_r, b0_r, c0_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      bb_r    <= bb_nxt;
      ac_r    <= ac_nxt;
      acneg_r <= (in_quad[W-1] != in_const[W-1]) && (in_const != '0);
      azero_r <= (in_quad == '0);
      bzero_r <= (in_lin == '0);
      a0_r    <= in_quad;
      b0_r    <= in_lin;
      c0_r    <= in_const;
    end
  end

  logic [PW+1:0] bbx, ac4, dsum, ddif;
  logic          dge;
  logic [DW-1:0] delta_nxt;
  kind_t         kind_nxt;

  assign bbx  = {2'b00, bb_r};
  assign ac4  = {ac_r, 2'b00};
  assign dsum = bbx + ac4;
  assign ddif = bbx - ac4;
  assign dge  = bbx >= ac4;

  always_comb begin
    if (acneg_r) begin
      delta_nxt = dsum[DW-1:0];
    end else if (dge) begin
      delta_nxt = ddif[DW-1:0];
    end else begin
      delta_nxt = '0;
    end
    if (azero_r) begin
      kind_nxt = bzero_r ? KIND_DEGEN : KIND_LINEAR;
    end else if (!acneg_r && !dge) begin
      kind_nxt = KIND_NONE;
    end else begin
      kind_nxt = KIND_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      out_delta <= delta_nxt;
      out_kind  <= kind_nxt;
      out_quad  <= a0_r;
      out_lin   <= b0_r;
      out_const <= c0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
    end
  end

endmodule

[rtl/qrs_sqrt.sv]
// ---------------------------------------------------------------------------
// qrs_sqrt: pipelined integer square root
// One result bit per stage, digit-by-digit, floor of the root.
// ---------------------------------------------------------------------------
module qrs_sqrt #(
  parameter int SW    = 33,
  parameter int TAG_W = 51
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2*SW-1:0]   in_rad,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SW-1:0]     out_root,
  output logic [TAG_W-1:0]  out_tag
);

  localparam int RW = SW + 2;

  logic [SW-1:0]   v_r;
  logic [SW:0]     rdy;
  logic [RW-1:0]   rem_r  [SW];
  logic [SW-1:0]   root_r [SW];
  logic [2*SW-1:0] rad_r  [SW];
  logic [TAG_W-1:0] tag_r [SW];

  assign rdy[SW]   = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = v_r[SW-1];
  assign out_root  = root_r[SW-1];
  assign out_tag   = tag_r[SW-1];

  for (genvar k = 0; k < SW; k++) begin : g_st
    logic [RW-1:0]    srem, cur, trial, diff;
    logic [SW-1:0]    sroot;
    logic [2*SW-1:0]  srad;
    logic [TAG_W-1:0] stag;
    logic             sv, ge;

    if (k == 0) begin : g_first
      assign srem  = '0;
      assign sroot = '0;
      assign srad  = in_rad;
      assign stag  = in_tag;
      assign sv    = in_valid;
    end else begin : g_next
      assign srem  = rem_r[k-1];
      assign sroot = root_r[k-1];
      assign srad  = rad_r[k-1];
      assign stag  = tag_r[k-1];
      assign sv    = v_r[k-1];
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];
    assign cur    = {srem[RW-3:0], srad[2*SW-1 -: 2]};
    assign trial  = {sroot, 2'b01};
    assign ge     = cur >= trial;
    assign diff   = cur - trial;

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        rem_r[k]  <= ge ? diff : cur;
        root_r[k] <= {sroot[SW-2:0], ge};
        rad_r[k]  <= srad << 2;
        tag_r[k]  <= stag;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= sv;
      end
    end
  end

endmodule

[rtl/qrs_div.sv]
// ---------------------------------------------------------------------------
// qrs_div: two-lane pipelined rounding divider
// A prep stage takes magnitudes and adds half the divisor, then one
// restoring quotient bit per stage on both lanes.
// ---------------------------------------------------------------------------
module qrs_div #(
  parameter int NW    = 35,
  parameter int DNW   = 17,
  parameter int TAG_W = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [NW-1:0]  in_num1,
  input  logic signed [NW-1:0]  in_num2,
  input  logic signed [DNW-1:0] in_den1,
  input  logic signed [DNW-1:0] in_den2,
  input  logic [TAG_W-1:0]      in_tag,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [NW-1:0]         out_q1,
  output logic [NW-1:0]         out_q2,
  output logic                  out_neg1,
  output logic                  out_neg2,
  output logic [TAG_W-1:0]      out_tag
);

  localparam int XW  = NW;
  localparam int UDW = DNW;
  localparam int NS  = XW + 1;

  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;

  assign rdy[NS]   = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end

  logic signed [NW-1:0]  num [2];
  logic signed [DNW-1:0] den [2];
  logic [XW-1:0]  px_nxt  [2];
  logic [UDW-1:0] pud_nxt [2];
  logic           pneg_nxt [2];

  assign num[0] = in_num1;
  assign num[1] = in_num2;
  assign den[0] = in_den1;
  assign den[1] = in_den2;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      pud_nxt[l]  = den[l][DNW-1] ? UDW'(-den[l]) : UDW'(den[l]);
      px_nxt[l]   = (num[l][NW-1] ? XW'((NW-1)'(-num[l])) : XW'((NW-1)'(num[l])))
                    + XW'(pud_nxt[l] >> 1);
      pneg_nxt[l] = num[l][NW-1] ^ den[l][DNW-1];
    end
  end

  logic [XW-1:0]    px_r   [2];
  logic [UDW-1:0]   pud_r  [2];
  logic             pneg_r [2];
  logic [TAG_W-1:0] ptag_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      px_r   <= px_nxt;
      pud_r  <= pud_nxt;
      pneg_r <= pneg_nxt;
      ptag_r <= in_tag;
    end
  end

  logic [XW-1:0]    x_r   [XW][2];
  logic [XW-1:0]    q_r   [XW][2];
  logic [UDW-1:0]   rem_r [XW][2];
  logic [UDW-1:0]   ud_r  [XW][2];
  logic             neg_r [XW][2];
  logic [TAG_W-1:0] tag_r [XW];

  for (genvar k = 0; k < XW; k++) begin : g_st
    logic [XW-1:0]    sx   [2];
    logic [XW-1:0]    sq   [2];
    logic [UDW-1:0]   srem [2];
    logic [UDW-1:0]   sud  [2];
    logic             sneg [2];
    logic [TAG_W-1:0] stag;
    logic [XW-1:0]    nx   [2];
    logic [XW-1:0]    nq   [2];
    logic [UDW-1:0]   nrem [2];

    if (k == 0) begin : g_first
      assign sx   = px_r;
      assign sq   = '{default: '0};
      assign srem = '{default: '0};
      assign sud  = pud_r;
      assign sneg = pneg_r;
      assign stag = ptag_r;
    end else begin : g_next
      assign sx   = x_r[k-1];
      assign sq   = q_r[k-1];
      assign srem = rem_r[k-1];
      assign sud  = ud_r[k-1];
      assign sneg = neg_r[k-1];
      assign stag = tag_r[k-1];
    end

    always_comb begin
      logic [UDW:0] cur, diff;
      logic         ge;
      for (int l = 0; l < 2; l++) begin
        cur     = {srem[l], sx[l][XW-1]};
        diff    = cur - {1'b0, sud[l]};
        ge      = cur >= {1'b0, sud[l]};
        nrem[l] = ge ? diff[UDW-1:0] : cur[UDW-1:0];
        nq[l]   = {sq[l][XW-2:0], ge};
        nx[l]   = sx[l] << 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k+1]) begin
        x_r[k]   <= nx;
        q_r[k]   <= nq;
        rem_r[k] <= nrem;
        ud_r[k]  <= sud;
        neg_r[k] <= sneg;
        tag_r[k] <= stag;
      end
    end
  end

  assign out_q1   = q_r[XW-1][0];
  assign out_q2   = q_r[XW-1][1];
  assign out_neg1 = neg_r[XW-1][0];
  assign out_neg2 = neg_r[XW-1][1];
  assign out_tag  = tag_r[XW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

endmodule

[rtl/quadratic_root_solver.sv]
// ---------------------------------------------------------------------------
// quadratic_root_solver: real roots of a*x^2 + b*x + c = 0
// Discriminant, pipelined square root and rounding dividers, then clipping
// of both roots to the signed 32-bit output range.
//
//   channel | direction | tdata                       | tuser
//   in_     | slave     | coef_quad, coef_lin, coef_const | -
//   out_    | master    | root_first, root_second     | root_kind, saturated
//
// One transfer per cycle on each side, sustained while out_tready stays high.
// The depth is set by the front stages, the bit-per-stage square root and
// quotient pipelines and the output register.
// Reset clears all valid bits; the data path has no reset.
// A stall fills bubbles first and holds every full stage in place.
// ---------------------------------------------------------------------------
module quadratic_root_solver
  import qrs_pkg::*;
#(
  parameter int COEF_WIDTH     = COEF_WIDTH_DEF,
  parameter int ROOT_FRAC_BITS = ROOT_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // coef_quad, coef_lin, coef_const
  input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]   in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // root_first, root_second
  output logic [2*ROOT_W-1:0]                 out_tdata,
  // root_kind, saturated
  output logic [KIND_W:0]                     out_tuser
);

  localparam int W   = COEF_WIDTH;
  localparam int R   = ROOT_FRAC_BITS;
  localparam int DW  = 2 * W + 1;
  localparam int SW  = W + R + 1;
  localparam int NW  = W + R + 3;
  localparam int DNW = W + 1;
  localparam int TW  = KIND_W + 3 * W;
  localparam int CW  = (NW + 1 > ROOT_W + 1) ? NW + 1 : ROOT_W + 1;
  localparam logic signed [CW-1:0] MAXC = CW'((64'd1 << (ROOT_W - 1)) - 64'd1);
  localparam logic signed [CW-1:0] MINC = ~MAXC;

  logic          f_valid, f_ready;
  logic [DW-1:0] f_delta;
  kind_t         f_kind;
  logic signed [W-1:0] f_a, f_b, f_c;

  qrs_front #(.COEF_WIDTH(W)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_quad   ($signed(in_tdata[W-1:0])),
    .in_lin    ($signed(in_tdata[2*W-1:W])),
    .in_const  ($signed(in_tdata[3*W-1:2*W])),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_delta (f_delta),
    .out_kind  (f_kind),
    .out_quad  (f_a),
    .out_lin   (f_b),
    .out_const (f_c)
  );

  logic          s_valid, s_ready;
  logic [SW-1:0] s_root;
  logic [TW-1:0] s_tag;

  qrs_sqrt #(.SW(SW), .TAG_W(TW)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_rad    ((2*SW)'(f_delta) << (2*R)),
    .in_tag    ({f_kind, f_a, f_b, f_c}),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_root  (s_root),
    .out_tag   (s_tag)
  );

  kind_t s_kind, s_kind2;
  logic signed [W-1:0]   s_a, s_b, s_c;
  logic signed [NW-1:0]  bx, cx, sx, nb, num1, num2;
  logic signed [DNW-1:0] den_a, den1;

  assign s_kind = kind_t'(s_tag[TW-1 -: KIND_W]);
  assign s_a    = $signed(s_tag[3*W-1:2*W]);
  assign s_b    = $signed(s_tag[2*W-1:W]);
  assign s_c    = $signed(s_tag[W-1:0]);
  assign bx     = NW'(s_b);
  assign cx     = NW'(s_c);
  assign sx     = $signed(NW'(s_root));
  assign nb     = -(bx <<< R);
  assign den_a  = $signed({s_a, 1'b0});
  assign num1   = (s_kind == KIND_LINEAR) ? -(cx <<< R) : nb + sx;
  assign num2   = nb - sx;
  assign den1   = (s_kind == KIND_LINEAR) ? DNW'(s_b) : den_a;
  assign s_kind2 = (s_kind == KIND_TWO && s_root == '0) ? KIND_DOUBLE : s_kind;

  logic              d_valid, d_ready;
  logic [NW-1:0]     d_q1, d_q2;
  logic              d_neg1, d_neg2;
  logic [KIND_W-1:0] d_tag;

  qrs_div #(.NW(NW), .DNW(DNW), .TAG_W(KIND_W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .in_num1   (num1),
    .in_num2   (num2),
    .in_den1   (den1),
    .in_den2   (den_a),
    .in_tag    (s_kind2),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_q1    (d_q1),
    .out_q2    (d_q2),
    .out_neg1  (d_neg1),
    .out_neg2  (d_neg2),
    .out_tag   (d_tag)
  );

  kind_t              d_kind;
  logic signed [CW-1:0] v1, v2;
  logic               hi1, lo1, hi2, lo2, use1, use2;
  logic [ROOT_W-1:0]  c1, c2;

  assign d_kind = kind_t'(d_tag);
  assign v1   = d_neg1 ? -$signed(CW'(d_q1)) : $signed(CW'(d_q1));
  assign v2   = d_neg2 ? -$signed(CW'(d_q2)) : $signed(CW'(d_q2));
  assign hi1  = v1 > MAXC;
  assign lo1  = v1 < MINC;
  assign hi2  = v2 > MAXC;
  assign lo2  = v2 < MINC;
  assign c1   = hi1 ? MAXC[ROOT_W-1:0] : (lo1 ? MINC[ROOT_W-1:0] : v1[ROOT_W-1:0]);
  assign c2   = hi2 ? MAXC[ROOT_W-1:0] : (lo2 ? MINC[ROOT_W-1:0] : v2[ROOT_W-1:0]);
  assign use1 = (d_kind == KIND_LINEAR) || (d_kind == KIND_DOUBLE) || (d_kind == KIND_TWO);
  assign use2 = (d_kind == KIND_TWO);

  logic              out_valid_r;
  logic [ROOT_W-1:0] first_r, second_r;
  kind_t             kind_r;
  logic              sat_r;

  assign d_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (d_ready) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready) begin
      first_r  <= use1 ? c1 : '0;
      second_r <= use2 ? c2 : '0;
      kind_r   <= d_kind;
      sat_r    <= (use1 && (hi1 || lo1)) || (use2 && (hi2 || lo2));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {second_r, first_r};
  assign out_tuser  = {sat_r, kind_r};

`ifndef NO_ASSERTIONS
  a_no_root_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[KIND_W-1:0] == KIND_NONE ||
                   out_tuser[KIND_W-1:0] == KIND_DEGEN)
    |-> out_tdata == '0 && !out_tuser[KIND_W])
    else $error("root values set without a real root");

  a_second_only_two : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[KIND_W-1:0] != KIND_TWO
    |-> out_tdata[2*ROOT_W-1:ROOT_W] == '0)
    else $error("second root set for a single-root kind");

  a_reset_idle : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
`endif

endmodule
